// ===== design/epdc_pkg.sv =====
// Shared types, constants and calendar helpers for the epoch/date converter.
// No dependencies; epdc_ctrl, epdc_dp and the top level import this package.
`default_nettype none

package epdc_pkg;

    localparam logic FUNC_TO_SECONDS = 1'b0;
    localparam logic FUNC_TO_DATE    = 1'b1;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [11:0] BASE_YEAR  = 12'd2000;
    localparam logic [11:0] MAX_YEAR   = 12'd2100;
    localparam logic [7:0]  MAX_OFFSET = 8'd100;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // Reciprocals for exact 32-bit division: x / 60 = (x * RECIP_60) >> 37,
    // x / 24 = (x * RECIP_24) >> 36
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

    // Division passes of the seconds-to-date path
    localparam logic [1:0] PASS_SEC  = 2'd0;
    localparam logic [1:0] PASS_MIN  = 2'd1;
    localparam logic [1:0] PASS_HOUR = 2'd2;

    typedef struct packed {
        logic load;
        logic yacc;
        logic macc;
        logic dayadd;
        logic mul;
        logic tadd;
        logic dstep;
        logic ystep;
        logic mstep;
        logic finish;
    } epdc_cmd_t;

    typedef struct packed {
        logic func;
        logic year_lt;
        logic mon_lt;
        logic pass_hour;
        logic ywalk_ge;
        logic mwalk_ge;
        logic out_free;
    } epdc_stat_t;

    // Years handled here lie in 1970..2106, where 2100 is the only
    // multiple of four that is not a leap year.
    function automatic logic is_leap(input logic [11:0] y);
        logic res;
        res = (y[1:0] == 2'b00) && (y != MAX_YEAR);
        return res;
    endfunction

    function automatic logic [8:0] year_days(input logic [11:0] y);
        logic [8:0] d;
        d = is_leap(y) ? 9'd366 : 9'd365;
        return d;
    endfunction

    // m counts from 0 = January
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/epdc_in_if.sv =====
// Request channel of the epoch/date converter: valid/ready plus request fields.
// Depends on nothing.
`default_nettype none

interface epdc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] epoch_seconds;
    logic [7:0]  in_year_offset;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;

    modport source (
        output valid, func, epoch_seconds, in_year_offset, in_month, in_day,
               in_hour, in_minute, in_second,
        input  ready
    );
    modport sink (
        input  valid, func, epoch_seconds, in_year_offset, in_month, in_day,
               in_hour, in_minute, in_second,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/epdc_out_if.sv =====
// Result channel of the epoch/date converter: valid/ready plus result fields.
// Depends on nothing.
`default_nettype none

interface epdc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_total;
    logic [6:0]  out_year_offset;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;

    modport source (
        output valid, seconds_total, out_year_offset, out_month, out_day,
               out_hour, out_minute, out_second,
        input  ready
    );
    modport sink (
        input  valid, seconds_total, out_year_offset, out_month, out_day,
               out_hour, out_minute, out_second,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/epdc_ctrl.sv =====
// Sequencer of the epoch/date converter: walks one item through its steps.
// Depends on epdc_pkg.
`default_nettype none

module epdc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire epdc_pkg::epdc_stat_t stat,
    output epdc_pkg::epdc_cmd_t     cmd
);
    import epdc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_YSUM  = 4'd1;
    localparam logic [3:0] S_MSUM  = 4'd2;
    localparam logic [3:0] S_DAY   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_TIME  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_YWALK = 4'd7;
    localparam logic [3:0] S_MWALK = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (stat.func == FUNC_TO_DATE) ? S_DIV : S_YSUM;
                end
            end
            S_YSUM:
            begin
                if (stat.year_lt)
                    cmd.yacc = 1'b1;
                else
                    state_next = S_MSUM;
            end
            S_MSUM:
            begin
                if (stat.mon_lt)
                    cmd.macc = 1'b1;
                else
                    state_next = S_DAY;
            end
            S_DAY:
            begin
                cmd.dayadd = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_TIME;
            end
            S_TIME:
            begin
                cmd.tadd   = 1'b1;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                cmd.dstep = 1'b1;
                if (stat.pass_hour)
                    state_next = S_YWALK;
            end
            S_YWALK:
            begin
                if (stat.ywalk_ge)
                    cmd.ystep = 1'b1;
                else
                    state_next = S_MWALK;
            end
            S_MWALK:
            begin
                if (stat.mwalk_ge)
                    cmd.mstep = 1'b1;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== design/epdc_dp.sv =====
// Datapath of the epoch/date converter: accumulators, reciprocal-multiply
// divider, year/month walk and the result register. Depends on epdc_pkg.
`default_nettype none

module epdc_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire epdc_pkg::epdc_cmd_t cmd,
    output epdc_pkg::epdc_stat_t    stat,
    input  wire logic               req_func,
    input  wire logic [31:0]        req_epoch_seconds,
    input  wire logic [7:0]         req_year_offset,
    input  wire logic [3:0]         req_month,
    input  wire logic [4:0]         req_day,
    input  wire logic [4:0]         req_hour,
    input  wire logic [5:0]         req_minute,
    input  wire logic [5:0]         req_second,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic [31:0]             rsp_seconds_total,
    output logic [6:0]              rsp_year_offset,
    output logic [3:0]              rsp_month,
    output logic [4:0]              rsp_day,
    output logic [4:0]              rsp_hour,
    output logic [5:0]              rsp_minute,
    output logic [5:0]              rsp_second
);
    import epdc_pkg::*;

    // work registers
    logic        func_reg;
    logic [11:0] year_reg, target_reg;
    logic [31:0] days_reg;
    logic [3:0]  mcnt_reg, mlimit_reg;
    logic [4:0]  day_reg, hour_reg;
    logic [5:0]  min_reg, sec_reg;
    logic [31:0] quo_reg;
    logic [1:0]  pass_reg;
    logic [5:0]  t_sec_reg, t_min_reg;
    logic [4:0]  t_hour_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] o_secs_reg;
    logic [6:0]  o_year_reg;
    logic [3:0]  o_month_reg;
    logic [4:0]  o_day_reg, o_hour_reg;
    logic [5:0]  o_min_reg, o_sec_reg;

    logic [31:0] recip;
    logic [63:0] prod;
    logic [31:0] qmul;
    logic [5:0]  rem_next;
    logic [31:0] quo_next;
    logic [11:0] target_in;
    logic [3:0]  mlimit_in;
    logic [31:0] tod_secs;

    always_comb
    begin
        // one division pass per cycle: quotient by reciprocal, remainder by
        // shift-and-add or shift-and-subtract back-multiply
        recip = (pass_reg == PASS_HOUR) ? RECIP_24 : RECIP_60;
        prod  = {32'd0, quo_reg} * {32'd0, recip};
        if (pass_reg == PASS_HOUR)
        begin
            quo_next = {4'd0, prod[63:36]};
            qmul     = {quo_next[27:0], 4'd0} + {quo_next[28:0], 3'd0};
        end
        else
        begin
            quo_next = {5'd0, prod[63:37]};
            qmul     = {quo_next[25:0], 6'd0} - {quo_next[29:0], 2'd0};
        end
        rem_next = 6'(quo_reg - qmul);

        target_in = (req_year_offset > MAX_OFFSET) ? MAX_YEAR
                  : 12'(BASE_YEAR + {4'd0, req_year_offset});
        if (req_month == 4'd0)
            mlimit_in = 4'd0;
        else if (req_month > (MONTHS_PER_YEAR + 4'd1))
            mlimit_in = MONTHS_PER_YEAR;
        else
            mlimit_in = req_month - 4'd1;

        tod_secs = ({27'd0, hour_reg} * {20'd0, SECS_PER_HOUR})
                 + ({26'd0, min_reg} * {26'd0, SECS_PER_MIN})
                 + {26'd0, sec_reg};
    end

    always_comb
    begin
        stat.func      = req_func;
        stat.year_lt   = year_reg < target_reg;
        stat.mon_lt    = mcnt_reg < mlimit_reg;
        stat.pass_hour = (pass_reg == PASS_HOUR);
        stat.ywalk_ge  = days_reg >= {23'd0, year_days(year_reg)};
        stat.mwalk_ge  = (mcnt_reg < MONTHS_PER_YEAR)
                       && (days_reg >= {27'd0, month_days(mcnt_reg, is_leap(year_reg))});
        stat.out_free  = !out_valid_reg || rsp_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= req_func;
            year_reg   <= EPOCH_YEAR;
            target_reg <= target_in;
            days_reg   <= '0;
            mcnt_reg   <= '0;
            mlimit_reg <= mlimit_in;
            day_reg    <= req_day;
            hour_reg   <= req_hour;
            min_reg    <= req_minute;
            sec_reg    <= req_second;
            quo_reg    <= req_epoch_seconds;
            pass_reg   <= PASS_SEC;
        end
        if (cmd.yacc)
        begin
            days_reg <= days_reg + {23'd0, year_days(year_reg)};
            year_reg <= year_reg + 12'd1;
        end
        if (cmd.macc)
        begin
            days_reg <= days_reg + {27'd0, month_days(mcnt_reg, is_leap(target_reg))};
            mcnt_reg <= mcnt_reg + 4'd1;
        end
        if (cmd.dayadd)
            days_reg <= days_reg + {27'd0, day_reg} - 32'd1;
        if (cmd.mul)
            days_reg <= days_reg * {15'd0, SECS_PER_DAY};
        if (cmd.tadd)
            days_reg <= days_reg + tod_secs;
        if (cmd.dstep)
        begin
            quo_reg  <= quo_next;
            pass_reg <= pass_reg + 2'd1;
            case (pass_reg)
                PASS_SEC: t_sec_reg <= rem_next;
                PASS_MIN: t_min_reg <= rem_next;
                default:
                begin
                    // quotient of the last pass is the day count
                    t_hour_reg <= rem_next[4:0];
                    days_reg   <= quo_next;
                    year_reg   <= EPOCH_YEAR;
                    mcnt_reg   <= '0;
                end
            endcase
        end
        if (cmd.ystep)
        begin
            days_reg <= days_reg - {23'd0, year_days(year_reg)};
            year_reg <= year_reg + 12'd1;
        end
        if (cmd.mstep)
        begin
            days_reg <= days_reg - {27'd0, month_days(mcnt_reg, is_leap(year_reg))};
            mcnt_reg <= mcnt_reg + 4'd1;
        end
        if (cmd.finish)
        begin
            if (func_reg == FUNC_TO_SECONDS)
            begin
                o_secs_reg  <= days_reg;
                o_year_reg  <= '0;
                o_month_reg <= '0;
                o_day_reg   <= '0;
                o_hour_reg  <= '0;
                o_min_reg   <= '0;
                o_sec_reg   <= '0;
            end
            else
            begin
                o_secs_reg  <= '0;
                o_year_reg  <= (year_reg >= BASE_YEAR) ? 7'(year_reg - BASE_YEAR) : 7'd0;
                o_month_reg <= mcnt_reg + 4'd1;
                o_day_reg   <= days_reg[4:0] + 5'd1;
                o_hour_reg  <= t_hour_reg;
                o_min_reg   <= t_min_reg;
                o_sec_reg   <= t_sec_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_seconds_total = o_secs_reg;
    assign rsp_year_offset   = o_year_reg;
    assign rsp_month         = o_month_reg;
    assign rsp_day           = o_day_reg;
    assign rsp_hour          = o_hour_reg;
    assign rsp_minute        = o_min_reg;
    assign rsp_second        = o_sec_reg;

endmodule

`default_nettype wire

// ===== design/epoch_date_converter_unit.sv =====
// Top level of the epoch/date converter: sequencer plus datapath.
// Depends on epdc_pkg, epdc_in_if, epdc_out_if, epdc_ctrl, epdc_dp.
//
//  port | dir | handshake   | carries
//  -----+-----+-------------+------------------------------------------
//  req  | in  | valid/ready | func, epoch_seconds, date and time fields
//  rsp  | out | valid/ready | seconds_total, date and time fields
//
// One item at a time. Date to seconds: one step per year since 1970 (up to
// 130) and per month before the given one (up to 12), then day add, multiply
// by seconds per day and time-of-day add. Seconds to date: division passes by
// 60, 60 and 24, then one step per year walked from 1970 (up to 136) and per
// month (up to 11). req.ready returns the cycle after the result is stored.
// req.ready is high only while the sequencer is idle; a finished result
// sits in the output register, and a new item may be taken while it waits.
// Reset is asynchronous and clears the sequencer and rsp.valid.
`default_nettype none

module epoch_date_converter_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    epdc_in_if.sink   req,
    epdc_out_if.source rsp
);
    import epdc_pkg::*;

    epdc_cmd_t  cmd;
    epdc_stat_t stat;
    logic       ready;

    epdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    epdc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_func          (req.func),
        .req_epoch_seconds (req.epoch_seconds),
        .req_year_offset   (req.in_year_offset),
        .req_month         (req.in_month),
        .req_day           (req.in_day),
        .req_hour          (req.in_hour),
        .req_minute        (req.in_minute),
        .req_second        (req.in_second),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_seconds_total (rsp.seconds_total),
        .rsp_year_offset   (rsp.out_year_offset),
        .rsp_month         (rsp.out_month),
        .rsp_day           (rsp.out_day),
        .rsp_hour          (rsp.out_hour),
        .rsp_minute        (rsp.out_minute),
        .rsp_second        (rsp.out_second)
    );

    assign req.ready = ready;

endmodule

`default_nettype wire

// ===== design/epdc_checker.sv =====
// Port-level checks for the epoch/date converter, bound to the top level.
// Depends on epoch_date_converter_unit and its interfaces.
`default_nettype none

module epdc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] seconds_total,
    input wire logic [6:0]  out_year_offset,
    input wire logic [3:0]  out_month,
    input wire logic [4:0]  out_day,
    input wire logic [4:0]  out_hour,
    input wire logic [5:0]  out_minute,
    input wire logic [5:0]  out_second
);

    // a result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seconds_total)
                                    && $stable(out_month) && $stable(out_day))
        else $error("result changed or dropped while stalled");

    // one item in flight: the block goes busy right after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous still in work");

    // a seconds result carries an all-zero date
    a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seconds_total != 32'd0 |->
            out_year_offset == 7'd0 && out_month == 4'd0 && out_day == 5'd0
            && out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0)
        else $error("seconds result with nonzero date fields");

    // a date result has in-range fields
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_month != 4'd0 |->
            out_month <= 4'd12 && out_day != 5'd0 && out_hour < 5'd24
            && out_minute < 6'd60 && out_second < 6'd60 && out_year_offset <= 7'd106)
        else $error("date result out of range");

endmodule

bind epoch_date_converter_unit epdc_checker u_epdc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .seconds_total   (rsp.seconds_total),
    .out_year_offset (rsp.out_year_offset),
    .out_month       (rsp.out_month),
    .out_day         (rsp.out_day),
    .out_hour        (rsp.out_hour),
    .out_minute      (rsp.out_minute),
    .out_second      (rsp.out_second)
);

`default_nettype wire
